// ----- hdl/rgbhps_pkg.sv -----
// Package for the RGB hue-preserving brightness step unit.
// Holds operation and selection codes, the microcode word format and the control store.
// No dependencies.
package rgbhps_pkg;

    // Operation codes carried in the input word's tuser field.
    localparam logic [2:0] OP_SEL_RED   = 3'd0;
    localparam logic [2:0] OP_SEL_GREEN = 3'd1;
    localparam logic [2:0] OP_SEL_BLUE  = 3'd2;
    localparam logic [2:0] OP_MIXED     = 3'd3;
    localparam logic [2:0] OP_LOAD      = 3'd4;
    localparam logic [2:0] OP_UP        = 3'd5;
    localparam logic [2:0] OP_DOWN      = 3'd6;

    // Selection codes.
    localparam logic [1:0] SEL_MIXED = 2'd0;
    localparam logic [1:0] SEL_RED   = 2'd1;
    localparam logic [1:0] SEL_GREEN = 2'd2;
    localparam logic [1:0] SEL_BLUE  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_LEVEL   = 2'd0;
    localparam logic [1:0] REG_STEP_SIZE   = 2'd1;
    localparam logic [1:0] REG_MIXED_FLOOR = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] MAX_LEVEL_RST   = 8'd255;
    localparam logic [7:0] STEP_SIZE_RST   = 8'd16;
    localparam logic [7:0] MIXED_FLOOR_RST = 8'd8;

    // Program counter width and step addresses.
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_IDLE    = 3'd0;
    localparam logic [PC_W-1:0] PC_DECODE  = 3'd1;
    localparam logic [PC_W-1:0] PC_MUL     = 3'd2;
    localparam logic [PC_W-1:0] PC_PREP    = 3'd3;
    localparam logic [PC_W-1:0] PC_DIV     = 3'd4;
    localparam logic [PC_W-1:0] PC_WRITE   = 3'd5;
    localparam logic [PC_W-1:0] PC_ADVANCE = 3'd6;
    localparam logic [PC_W-1:0] PC_FINISH  = 3'd7;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_DECODE,
        UOP_MUL,
        UOP_PREP,
        UOP_DIV,
        UOP_WRITE,
        UOP_ADVANCE,
        UOP_FINISH
    } uop_t;

    // Jump condition selected by a control word.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_NOT_MIXED,
        COND_CUR_ZERO,
        COND_BIT_MORE,
        COND_MORE_CH,
        COND_OUT_BUSY
    } cond_t;

    // One control word: datapath operation, jump condition and jump target.
    typedef struct packed {
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Control store. When the condition holds the sequencer jumps to the
    // target, otherwise it moves to the next step; the last step wraps to idle.
    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            PC_IDLE:    w = '{UOP_WAIT,    COND_NO_INPUT,  PC_IDLE};
            PC_DECODE:  w = '{UOP_DECODE,  COND_NOT_MIXED, PC_FINISH};
            PC_MUL:     w = '{UOP_MUL,     COND_CUR_ZERO,  PC_ADVANCE};
            PC_PREP:    w = '{UOP_PREP,    COND_NEVER,     PC_IDLE};
            PC_DIV:     w = '{UOP_DIV,     COND_BIT_MORE,  PC_DIV};
            PC_WRITE:   w = '{UOP_WRITE,   COND_NEVER,     PC_IDLE};
            PC_ADVANCE: w = '{UOP_ADVANCE, COND_MORE_CH,   PC_MUL};
            PC_FINISH:  w = '{UOP_FINISH,  COND_OUT_BUSY,  PC_FINISH};
            default:    w = '{UOP_WAIT,    COND_NEVER,     PC_IDLE};
        endcase
        return w;
    endfunction

    // Next channel index in red, green, blue order, wrapping after blue.
    function automatic logic [1:0] next_chan(input logic [1:0] c);
        logic [1:0] n;
        case (c)
            2'd0:    n = 2'd1;
            2'd1:    n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    // Step up with saturation at the highest level.
    function automatic logic [7:0] step_up(input logic [7:0] v, input logic [7:0] step,
                                           input logic [7:0] max_lvl);
        logic [8:0] s;
        s = {1'b0, v} + {1'b0, step};
        return (s > {1'b0, max_lvl}) ? max_lvl : s[7:0];
    endfunction

endpackage

// ----- hdl/rgb_hue_preserving_brightness_step_unit.sv -----
// Top level of the RGB hue-preserving brightness step unit.
// A microcoded sequencer drives a small datapath with a serial divider.
// Depends on rgbhps_pkg.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tuser: operation, tdata: load levels
// m_axis    out        m_axis_tvalid/tready       tdata: levels, selection, active count
// apb       in         psel/penable, pready = 1   max_level, step_size, mixed_floor
//
// A select, load or single-channel step goes from decode straight to the finish step.
// A mixed step runs multiply, prepare, divide, write and advance for each scaled channel,
// the restoring divider retiring one quotient bit per cycle; a zero channel skips to advance.
// The next word is accepted while a result still waits in the output register;
// the sequencer holds in its last step only if that register is still full.
// Reset clears the levels, selects mixed mode and loads the register defaults.
module rgb_hue_preserving_brightness_step_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // load_red[7:0], load_green[15:8], load_blue[23:16]
    input  logic [2:0]  s_axis_tuser,   // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16],
                                        // selected_channel[25:24], active_count[27:26]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Sequencer and configuration state.
    logic [rgbhps_pkg::PC_W-1:0] pc_reg, pc_next;
    rgbhps_pkg::ucode_t          cw;
    logic                        take;
    logic [7:0] max_reg, step_reg, floor_reg;

    // Datapath state.
    logic [7:0]  lvl_reg [3];
    logic [7:0]  lvl_next [3];
    logic [1:0]  sel_reg, sel_next;
    logic [2:0]  op_reg, op_next;
    logic [23:0] ld_reg, ld_next;
    logic [1:0]  ref_reg, ref_next;
    logic [1:0]  chan_reg, chan_next;
    logic [7:0]  old_reg, old_next;
    logic [7:0]  new_reg, new_next;
    logic [16:0] num_reg, num_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dsh_reg, dsh_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  quo_reg, quo_next;
    logic        sat_reg, sat_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    // Helper signals.
    logic        in_fire, out_busy, cfg_write;
    logic [1:0]  active;
    logic [1:0]  active_after;
    logic        step_op, up, mixed_go;
    logic [1:0]  ref_c;
    logic [7:0]  ref_lvl, mix_new;
    logic [8:0]  floor_sum;
    logic [1:0]  single_c;
    logic [7:0]  single_lvl, single_new;
    logic [7:0]  cur_lvl;
    logic [15:0] prod;
    logic [8:0]  den;
    logic        ge;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign s_axis_tready = (pc_reg == rgbhps_pkg::PC_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;

    // Register readback.
    always_comb
    begin
        case (paddr[3:2])
            rgbhps_pkg::REG_MAX_LEVEL:   prdata = {24'd0, max_reg};
            rgbhps_pkg::REG_STEP_SIZE:   prdata = {24'd0, step_reg};
            rgbhps_pkg::REG_MIXED_FLOOR: prdata = {24'd0, floor_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= rgbhps_pkg::MAX_LEVEL_RST;
            step_reg  <= rgbhps_pkg::STEP_SIZE_RST;
            floor_reg <= rgbhps_pkg::MIXED_FLOOR_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                rgbhps_pkg::REG_MAX_LEVEL:   max_reg   <= pwdata[7:0];
                rgbhps_pkg::REG_STEP_SIZE:   step_reg  <= pwdata[7:0];
                rgbhps_pkg::REG_MIXED_FLOOR: floor_reg <= pwdata[7:0];
                default:                     ;
            endcase
        end
    end

    // Active channel counts before and after this word's update.
    assign active = {1'b0, lvl_reg[0] != 8'd0} + {1'b0, lvl_reg[1] != 8'd0}
                  + {1'b0, lvl_reg[2] != 8'd0};
    assign active_after = {1'b0, lvl_next[0] != 8'd0} + {1'b0, lvl_next[1] != 8'd0}
                        + {1'b0, lvl_next[2] != 8'd0};

    // Operation decode.
    assign step_op  = (op_reg == rgbhps_pkg::OP_UP) || (op_reg == rgbhps_pkg::OP_DOWN);
    assign up       = (op_reg == rgbhps_pkg::OP_UP);
    assign mixed_go = step_op && (sel_reg == rgbhps_pkg::SEL_MIXED) && (active > 2'd1);

    // Reference channel: largest nonzero for up, smallest for down, first on a tie.
    always_comb
    begin
        ref_c = 2'd0;
        if (lvl_reg[1] != 8'd0 && (lvl_reg[0] == 8'd0 ||
            (up ? (lvl_reg[1] > lvl_reg[0]) : (lvl_reg[1] < lvl_reg[0]))))
        begin
            ref_c = 2'd1;
        end
        if (lvl_reg[2] != 8'd0 && (lvl_reg[ref_c] == 8'd0 ||
            (up ? (lvl_reg[2] > lvl_reg[ref_c]) : (lvl_reg[2] < lvl_reg[ref_c]))))
        begin
            ref_c = 2'd2;
        end
    end

    // New level of the reference channel in a mixed step.
    assign ref_lvl   = lvl_reg[ref_c];
    assign floor_sum = {1'b0, floor_reg} + {1'b0, step_reg};
    always_comb
    begin
        if (up)
        begin
            mix_new = rgbhps_pkg::step_up(ref_lvl, step_reg, max_reg);
        end
        else if ({1'b0, ref_lvl} < floor_sum)
        begin
            mix_new = floor_reg;
        end
        else
        begin
            mix_new = ref_lvl - step_reg;
        end
    end

    // Single-channel step on the selected channel.
    assign single_c   = sel_reg - 2'd1;
    assign single_lvl = (single_c == 2'd0) ? lvl_reg[0] :
                        (single_c == 2'd1) ? lvl_reg[1] : lvl_reg[2];
    always_comb
    begin
        if (up)
        begin
            single_new = rgbhps_pkg::step_up(single_lvl, step_reg, max_reg);
        end
        else if (single_lvl < step_reg)
        begin
            single_new = 8'd0;
        end
        else
        begin
            single_new = single_lvl - step_reg;
        end
    end

    // Channel being scaled, its product with the new reference, the divisor.
    assign cur_lvl = (chan_reg == 2'd0) ? lvl_reg[0] :
                     (chan_reg == 2'd1) ? lvl_reg[1] : lvl_reg[2];
    assign prod    = {8'd0, cur_lvl} * {8'd0, new_reg};
    assign den     = {old_reg, 1'b0};
    assign ge      = (rem_reg >= {1'b0, dsh_reg});

    // Sequencer: fetch the control word, evaluate its condition, advance.
    always_comb
    begin
        cw = rgbhps_pkg::ucode(pc_reg);
        case (cw.cond)
            rgbhps_pkg::COND_NEVER:     take = 1'b0;
            rgbhps_pkg::COND_NO_INPUT:  take = !in_fire;
            rgbhps_pkg::COND_NOT_MIXED: take = !mixed_go;
            rgbhps_pkg::COND_CUR_ZERO:  take = (cur_lvl == 8'd0);
            rgbhps_pkg::COND_BIT_MORE:  take = (bit_reg != 3'd0);
            rgbhps_pkg::COND_MORE_CH:   take = (rgbhps_pkg::next_chan(chan_reg) != ref_reg);
            rgbhps_pkg::COND_OUT_BUSY:  take = out_busy;
            default:                    take = 1'b0;
        endcase
        // The finish step is the last address, so the increment wraps to idle.
        pc_next = take ? cw.target : pc_reg + 3'd1;
    end

    // Datapath, driven by the current control word.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lvl_next[c] = lvl_reg[c];
        end
        sel_next       = sel_reg;
        op_next        = op_reg;
        ld_next        = ld_reg;
        ref_next       = ref_reg;
        chan_next      = chan_reg;
        old_next       = old_reg;
        new_next       = new_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        bit_next       = bit_reg;
        quo_next       = quo_reg;
        sat_next       = sat_reg;
        out_valid_next = (out_valid_reg && !m_axis_tready);
        out_data_next  = out_data_reg;
        case (cw.uop)
            rgbhps_pkg::UOP_WAIT:
            begin
                if (in_fire)
                begin
                    op_next = s_axis_tuser;
                    ld_next = s_axis_tdata;
                end
            end
            rgbhps_pkg::UOP_DECODE:
            begin
                case (op_reg)
                    rgbhps_pkg::OP_SEL_RED:   sel_next = rgbhps_pkg::SEL_RED;
                    rgbhps_pkg::OP_SEL_GREEN: sel_next = rgbhps_pkg::SEL_GREEN;
                    rgbhps_pkg::OP_SEL_BLUE:  sel_next = rgbhps_pkg::SEL_BLUE;
                    rgbhps_pkg::OP_MIXED:     sel_next = rgbhps_pkg::SEL_MIXED;
                    rgbhps_pkg::OP_LOAD:
                    begin
                        lvl_next[0] = ld_reg[7:0];
                        lvl_next[1] = ld_reg[15:8];
                        lvl_next[2] = ld_reg[23:16];
                    end
                    rgbhps_pkg::OP_UP, rgbhps_pkg::OP_DOWN:
                    begin
                        if (sel_reg != rgbhps_pkg::SEL_MIXED)
                        begin
                            for (int c = 0; c < 3; c++)
                            begin
                                if (single_c == 2'(c))
                                begin
                                    lvl_next[c] = single_new;
                                end
                            end
                        end
                        else if (mixed_go)
                        begin
                            for (int c = 0; c < 3; c++)
                            begin
                                if (ref_c == 2'(c))
                                begin
                                    lvl_next[c] = mix_new;
                                end
                            end
                            ref_next  = ref_c;
                            old_next  = ref_lvl;
                            new_next  = mix_new;
                            chan_next = rgbhps_pkg::next_chan(ref_c);
                        end
                    end
                    default: ;
                endcase
            end
            rgbhps_pkg::UOP_MUL:
            begin
                // Numerator of the rounded ratio: 2 * v * new + old.
                num_next = {prod, 1'b0} + {9'd0, old_reg};
            end
            rgbhps_pkg::UOP_PREP:
            begin
                // A quotient of 256 or more saturates whatever the highest level is.
                sat_next = (num_reg >= {den, 8'd0});
                rem_next = num_reg;
                dsh_next = {den, 7'd0};
                bit_next = 3'd7;
                quo_next = 8'd0;
            end
            rgbhps_pkg::UOP_DIV:
            begin
                // One restoring division step, most significant quotient bit first.
                if (ge)
                begin
                    rem_next = rem_reg - {1'b0, dsh_reg};
                end
                quo_next = {quo_reg[6:0], ge};
                dsh_next = dsh_reg >> 1;
                bit_next = bit_reg - 3'd1;
            end
            rgbhps_pkg::UOP_WRITE:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (chan_reg == 2'(c))
                    begin
                        lvl_next[c] = (sat_reg || quo_reg > max_reg) ? max_reg : quo_reg;
                    end
                end
            end
            rgbhps_pkg::UOP_ADVANCE:
            begin
                if (rgbhps_pkg::next_chan(chan_reg) != ref_reg)
                begin
                    chan_next = rgbhps_pkg::next_chan(chan_reg);
                end
            end
            rgbhps_pkg::UOP_FINISH:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, active_after, sel_reg,
                                      lvl_reg[2], lvl_reg[1], lvl_reg[0]};
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= rgbhps_pkg::PC_IDLE;
            sel_reg       <= rgbhps_pkg::SEL_MIXED;
            ref_reg       <= 2'd0;
            chan_reg      <= 2'd0;
            bit_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                lvl_reg[c] <= 8'd0;
            end
        end
        else
        begin
            pc_reg        <= pc_next;
            sel_reg       <= sel_next;
            ref_reg       <= ref_next;
            chan_reg      <= chan_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < 3; c++)
            begin
                lvl_reg[c] <= lvl_next[c];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ld_reg       <= ld_next;
        old_reg      <= old_next;
        new_reg      <= new_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        sat_reg      <= sat_next;
        out_data_reg <= out_data_next;
    end

    // An accepted word is decoded in the following cycle.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> pc_reg == rgbhps_pkg::PC_DECODE)
        else $error("accepted word was not decoded next");

    // The divider counts its bits down without skipping.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rgbhps_pkg::PC_DIV && bit_reg != 3'd0)
        |=> (pc_reg == rgbhps_pkg::PC_DIV && bit_reg == $past(bit_reg) - 3'd1))
        else $error("divider bit count out of step");

    // The reference channel is never scaled against itself.
    a_chan_not_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rgbhps_pkg::PC_MUL || pc_reg == rgbhps_pkg::PC_WRITE ||
         pc_reg == rgbhps_pkg::PC_ADVANCE) |-> (chan_reg != ref_reg && chan_reg != 2'd3))
        else $error("scaled channel equals the reference");

    // A full output register holds the sequencer in its finish step.
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rgbhps_pkg::PC_FINISH && out_busy)
        |=> (pc_reg == rgbhps_pkg::PC_FINISH && out_valid_reg))
        else $error("result overwrote a waiting word");

endmodule

// ----- tb/rgb_hue_preserving_brightness_step_unit_tb.sv -----
// Testbench for the RGB hue-preserving brightness step unit: directed and random words
// are checked field by field against a behavioral predictor of levels and selection.
// Depends on rgbhps_pkg and rgb_hue_preserving_brightness_step_unit.
module rgb_hue_preserving_brightness_step_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbhps_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [2:0] OP_UNUSED = 3'd7;
    // Cycles watched for stray words after the last expected one.
    localparam int TAIL_CYCLES = 60;
    // Words sent for each register setting in the random part.
    localparam int WORDS_PER_SETTING = 190;

    // One result word as the block reports it.
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] sel;
        logic [1:0] active;
    } led_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // load_red[7:0], load_green[15:8], load_blue[23:16]
    logic [2:0]  s_axis_tuser = '0;   // operation[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // red[7:0], green[15:8], blue[23:16],
                                      // selected_channel[25:24], active_count[27:26]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted levels, selection and register copies.
    logic [7:0] lvl [3];
    logic [1:0] cur_sel;
    logic [7:0] max_lvl;
    logic [7:0] step_lvl;
    logic [7:0] floor_lvl;

    led_word_t  pending_levels[$];
    int         mismatch_count = 0;
    bit         steady = 1'b0;

    rgb_hue_preserving_brightness_step_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    // Number of channels that are lit.
    function automatic logic [1:0] lit_count();
        logic [1:0] n;
        n = 2'd0;
        for (int c = 0; c < 3; c++)
            if (lvl[c] != 8'd0)
                n = n + 2'd1;
        return n;
    endfunction

    // A step on the one selected channel, saturating at the top or at zero.
    function automatic void step_single(input int c, input bit rising);
        logic [8:0] sum;
        sum = {1'b0, lvl[c]} + {1'b0, step_lvl};
        if (rising)
            lvl[c] = (sum > {1'b0, max_lvl}) ? max_lvl : sum[7:0];
        else
            lvl[c] = (lvl[c] < step_lvl) ? 8'd0 : lvl[c] - step_lvl;
    endfunction

    // A mixed step: move the anchor channel, then scale the other lit channels
    // by new/old with halves rounded up, capped at the highest level.
    function automatic void step_mixed(input bit rising);
        int          anchor;
        int unsigned old_v;
        int unsigned new_v;
        int unsigned q;
        anchor = -1;
        for (int c = 0; c < 3; c++)
            if (lvl[c] != 8'd0 && (anchor < 0 ||
                (rising ? lvl[c] > lvl[anchor] : lvl[c] < lvl[anchor])))
                anchor = c;
        if (anchor < 0)
            return;
        old_v = 32'(lvl[anchor]);
        if (rising)
            new_v = (old_v + 32'(step_lvl) > 32'(max_lvl)) ? 32'(max_lvl)
                                                          : old_v + 32'(step_lvl);
        else
            new_v = (old_v < 32'(floor_lvl) + 32'(step_lvl)) ? 32'(floor_lvl)
                                                             : old_v - 32'(step_lvl);
        lvl[anchor] = new_v[7:0];
        for (int c = 0; c < 3; c++)
        begin
            if (c != anchor && lvl[c] != 8'd0)
            begin
                q = (32'd2 * 32'(lvl[c]) * new_v + old_v) / (32'd2 * old_v);
                lvl[c] = (q > 32'(max_lvl)) ? max_lvl : q[7:0];
            end
        end
    endfunction

    // Advance the predicted state by one input word and return the expected result.
    function automatic led_word_t apply_word(input logic [2:0] op, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
        led_word_t w;
        case (op)
            OP_SEL_RED:   cur_sel = SEL_RED;
            OP_SEL_GREEN: cur_sel = SEL_GREEN;
            OP_SEL_BLUE:  cur_sel = SEL_BLUE;
            OP_MIXED:     cur_sel = SEL_MIXED;
            OP_LOAD:
            begin
                lvl[0] = r;
                lvl[1] = g;
                lvl[2] = b;
            end
            OP_UP, OP_DOWN:
            begin
                if (cur_sel != SEL_MIXED)
                    step_single(int'(cur_sel) - 1, op == OP_UP);
                else if (lit_count() > 2'd1)
                    step_mixed(op == OP_UP);
            end
            default: ;
        endcase
        w.red    = lvl[0];
        w.green  = lvl[1];
        w.blue   = lvl[2];
        w.sel    = cur_sel;
        w.active = lit_count();
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Receiver: random stalls, and each accepted word checked against the oldest
    // expectation.
    always @(posedge clk)
    begin
        led_word_t want;
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_levels.size() == 0)
            begin
                report_mismatch("unexpected word", m_axis_tdata, 32'd0);
            end
            else
            begin
                want = pending_levels.pop_front();
                if (m_axis_tdata[7:0] !== want.red)
                    report_mismatch("red_level", 32'(m_axis_tdata[7:0]), 32'(want.red));
                if (m_axis_tdata[15:8] !== want.green)
                    report_mismatch("green_level", 32'(m_axis_tdata[15:8]),
                                    32'(want.green));
                if (m_axis_tdata[23:16] !== want.blue)
                    report_mismatch("blue_level", 32'(m_axis_tdata[23:16]),
                                    32'(want.blue));
                if (m_axis_tdata[25:24] !== want.sel)
                    report_mismatch("selected_channel", 32'(m_axis_tdata[25:24]),
                                    32'(want.sel));
                if (m_axis_tdata[27:26] !== want.active)
                    report_mismatch("active_count", 32'(m_axis_tdata[27:26]),
                                    32'(want.active));
            end
        end
    end

    // Send one word; returns at the edge that accepted it with tvalid still high.
    task automatic send_word(input logic [2:0] op, input logic [7:0] r = 8'd0,
                             input logic [7:0] g = 8'd0, input logic [7:0] b = 8'd0);
        bit taken;
        if (!steady && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, g, r};
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        pending_levels.push_back(apply_word(op, r, g, b));
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register updates at its end.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        bit done;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAX_LEVEL:   max_lvl   = value;
            REG_STEP_SIZE:   step_lvl  = value;
            REG_MIXED_FLOOR: floor_lvl = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] top, input logic [7:0] stride,
                              input logic [7:0] floor_val);
        write_reg(REG_MAX_LEVEL, top);
        write_reg(REG_STEP_SIZE, stride);
        write_reg(REG_MIXED_FLOOR, floor_val);
    endtask

    // Level biased toward zero, small values and the top of the range.
    function automatic logic [7:0] pick_level();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25)
            return 8'd0;
        else if (p < 50)
            return 8'($urandom_range(1, 20));
        else if (p < 65)
            return 8'($urandom_range(240, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    // Random word: mostly steps and loads that keep several channels lit.
    task automatic send_random_word();
        int         p;
        logic [2:0] op;
        p = $urandom_range(0, 99);
        if (p < 14)
            op = OP_LOAD;
        else if (p < 40)
            op = OP_UP;
        else if (p < 70)
            op = OP_DOWN;
        else if (p < 97)
            op = ($urandom_range(0, 1) != 0) ? OP_MIXED : 3'($urandom_range(0, 2));
        else
            op = OP_UNUSED;
        if (op == OP_LOAD)
            send_word(op, pick_level(), pick_level(), pick_level());
        else
            send_word(op, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Selection codes, loads, mixed and single-channel steps and the ignored code.
    task automatic test_select_and_load();
        send_word(OP_UNUSED);
        send_word(OP_UP);
        send_word(OP_LOAD, 8'd255, 8'd255, 8'd255);
        send_word(OP_UP);
        send_word(OP_DOWN);
        send_word(OP_SEL_RED);
        send_word(OP_UP);
        send_word(OP_DOWN);
        send_word(OP_SEL_GREEN);
        send_word(OP_LOAD, 8'd0, 8'd7, 8'd0);
        send_word(OP_DOWN);
        send_word(OP_SEL_BLUE);
        send_word(OP_UP);
    endtask

    // Mixed steps: one lit channel, scaling, raise to the floor, capped scaling.
    task automatic test_mixed_scaling();
        send_word(OP_MIXED);
        send_word(OP_LOAD, 8'd0, 8'd40, 8'd0);
        send_word(OP_UP);
        send_word(OP_LOAD, 8'd200, 8'd100, 8'd50);
        send_word(OP_UP);
        send_word(OP_DOWN);
        send_word(OP_LOAD, 8'd3, 8'd5, 8'd0);
        send_word(OP_DOWN);
        send_word(OP_LOAD, 8'd250, 8'd1, 8'd1);
        send_word(OP_UP);
        send_word(OP_LOAD, 8'd0, 8'd128, 8'd255);
        send_word(OP_DOWN);
        wait_drained();
    endtask

    // Random traffic under a series of register settings, extremes included;
    // the registers change only once the block has drained.
    task automatic test_random_settings();
        logic [7:0] tops [8]    = '{8'd255, 8'd255, 8'd255, 8'd1, 8'd1, 8'd100, 8'd200, 8'd150};
        logic [7:0] strides [8] = '{8'd16, 8'd1, 8'd255, 8'd1, 8'd255, 8'd16, 8'd40, 8'd7};
        logic [7:0] floors [8]  = '{8'd8, 8'd0, 8'd255, 8'd0, 8'd255, 8'd200, 8'd30, 8'd1};
        for (int s = 0; s < 8; s++)
        begin
            set_config(tops[s], strides[s], floors[s]);
            steady = (s == 6);
            for (int i = 0; i < WORDS_PER_SETTING; i++)
                send_random_word();
            wait_drained();
        end
        steady = 1'b0;
    endtask

    // Back-to-back words with both sides always ready.
    task automatic test_streaming_burst();
        set_config(MAX_LEVEL_RST, STEP_SIZE_RST, MIXED_FLOOR_RST);
        steady = 1'b1;
        for (int i = 0; i < 80; i++)
            send_random_word();
        wait_drained();
        steady = 1'b0;
    endtask

    initial
    begin
        max_lvl   = MAX_LEVEL_RST;
        step_lvl  = STEP_SIZE_RST;
        floor_lvl = MIXED_FLOOR_RST;
        cur_sel   = SEL_MIXED;
        for (int c = 0; c < 3; c++)
            lvl[c] = 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_select_and_load();
        test_mixed_scaling();
        test_random_settings();
        test_streaming_burst();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard limit on run time.
    initial
    begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rgbhps_pkg.sv
hdl/rgb_hue_preserving_brightness_step_unit.sv
tb/rgb_hue_preserving_brightness_step_unit_tb.sv
